@@ hw/rtl/gfla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gfla_pkg;

	localparam int MAX_DEGREE_DEF = 8;
	localparam int MIN_DEGREE     = 2;
	localparam int VALUE_W        = 8;
	localparam int DEGREE_W       = 4;
	localparam int TAPS_W         = 8;
	localparam int CFG_DATA_W     = 8;
	localparam int CFG_INDEX_W    = 1;

	localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd8;
	localparam logic [TAPS_W-1:0]   TAPS_RESET   = 8'd29;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FIELD_DEGREE = 1'b0,
		REG_POLY_TAPS    = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_BUILD  = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WALK,
		ST_INV,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

@@ hw/rtl/gfla_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/gf2m_log_antilog_table_engine_top.sv @@
`timescale 1ns / 1ps
// lookup: rams read on accept; result registered once the output is free, then ready returns
// build: from accept to the result beat, one table entry per cycle in each
// of three passes (log clear, lfsr walk, pipelined inverse fill), all through single-port-write rams
// in_ready is low while an item is in work; a waiting result does not block acceptance
// reset: arst_n async low; registers back to degree 8, taps 29, tables marked unbuilt
`default_nettype none

module gf2m_log_antilog_table_engine_top
	import gfla_pkg::*;
#(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   op,
	input  wire logic [VALUE_W-1:0]     value,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [VALUE_W-1:0]     log_result,
	output logic      [VALUE_W-1:0]     antilog_result,
	output logic      [VALUE_W-1:0]     inverse_result,
	output logic                        zero_input,
	output logic                        out_of_range,
	output logic                        not_built
);

	localparam int AW     = MAX_DEGREE;
	localparam int DEPTH  = 1 << AW;
	localparam int WIDE_W = (AW > VALUE_W) ? AW : VALUE_W;

	state_t state_q, state_d;

	logic [DEGREE_W-1:0] field_degree_q;
	logic [TAPS_W-1:0]   poly_taps_q;
	logic                tables_valid_q;

	logic [AW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] a_q, a_d;
	logic          issue_q, issue_d;
	logic          v_s1, v_s2;
	logic [AW-1:0] idx_s1, idx_s2;

	op_t                op_q;
	logic [VALUE_W-1:0] value_q;

	logic               out_valid_q;
	logic [VALUE_W-1:0] log_q, antilog_q, inverse_q;
	logic               zero_q, oor_q, nb_q;

	logic load_out, set_valid;

	logic [DEGREE_W-1:0] m_eff;
	logic [AW-1:0]       n_mask, top_mask, taps_m, lfsr_next, e_addr, look_addr;
	logic [WIDE_W-1:0]   taps_wide;

	logic          pw_we, lg_we, iv_we, pw_re, lg_re, iv_re;
	logic [AW-1:0] pw_waddr, lg_waddr, iv_waddr, pw_raddr, lg_raddr;
	logic [AW-1:0] pw_wdata, lg_wdata, iv_wdata;
	logic [AW-1:0] pw_rd, lg_rd, iv_rd;

	// field shape from the registers
	always_comb begin
		if (field_degree_q < DEGREE_W'(MIN_DEGREE)) begin
			m_eff = DEGREE_W'(MIN_DEGREE);
		end else if (field_degree_q > DEGREE_W'(MAX_DEGREE)) begin
			m_eff = DEGREE_W'(MAX_DEGREE);
		end else begin
			m_eff = field_degree_q;
		end
		for (int b = 0; b < AW; b++) begin
			n_mask[b]   = (b < int'(m_eff));
			top_mask[b] = (b == int'(m_eff) - 1);
		end
	end

	assign taps_wide = WIDE_W'(poly_taps_q);
	assign taps_m    = AW'(taps_wide) & n_mask;

	// multiply by alpha
	assign lfsr_next = ((a_q & top_mask) != '0) ?
		((((a_q ^ top_mask) << 1) ^ taps_m) & n_mask) : ((a_q << 1) & n_mask);

	// inverse exponent (N - log) mod N, log is always below N
	assign e_addr    = (lg_rd == '0) ? '0 : (n_mask - lg_rd);
	assign look_addr = AW'(value);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		a_d       = a_q;
		issue_d   = issue_q;
		load_out  = 1'b0;
		set_valid = 1'b0;
		in_ready  = 1'b0;
		pw_we     = 1'b0;
		pw_waddr  = cnt_q;
		pw_wdata  = a_q;
		lg_we     = 1'b0;
		lg_waddr  = cnt_q;
		lg_wdata  = '0;
		lg_re     = 1'b0;
		lg_raddr  = look_addr;
		pw_re     = 1'b0;
		pw_raddr  = look_addr;
		iv_re     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (op_t'(op) == OP_LOOKUP) begin
						lg_re   = 1'b1;
						pw_re   = 1'b1;
						iv_re   = 1'b1;
						state_d = ST_FIN;
					end else begin
						cnt_d   = '0;
						state_d = ST_CLEAR;
					end
				end
			end
			ST_CLEAR: begin
				lg_we = 1'b1;
				if (cnt_q == n_mask) begin
					cnt_d   = '0;
					a_d     = AW'(1);
					state_d = ST_WALK;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			ST_WALK: begin
				pw_we = 1'b1;
				lg_we = 1'b1;
				if (cnt_q == n_mask) begin
					// last antilog entry is 1, log of zero forced to 0
					pw_wdata = AW'(1);
					lg_waddr = '0;
					lg_wdata = '0;
					cnt_d    = '0;
					issue_d  = 1'b1;
					state_d  = ST_INV;
				end else begin
					lg_waddr = a_q;
					lg_wdata = cnt_q;
					a_d      = lfsr_next;
					cnt_d    = cnt_q + AW'(1);
				end
			end
			ST_INV: begin
				if (issue_q) begin
					lg_re    = 1'b1;
					lg_raddr = cnt_q;
					if (cnt_q == n_mask) begin
						issue_d = 1'b0;
					end else begin
						cnt_d = cnt_q + AW'(1);
					end
				end
				if (v_s1) begin
					pw_re    = 1'b1;
					pw_raddr = e_addr;
				end
				if (!issue_q && !v_s1 && !v_s2) begin
					set_valid = 1'b1;
					state_d   = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign iv_we    = v_s2;
	assign iv_waddr = idx_s2;
	assign iv_wdata = (idx_s2 == '0) ? '0 : pw_rd;

	gfla_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_power_ram (
		.clk   (clk),
		.we    (pw_we),
		.waddr (pw_waddr),
		.wdata (pw_wdata),
		.re    (pw_re),
		.raddr (pw_raddr),
		.rdata (pw_rd)
	);

	gfla_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_log_ram (
		.clk   (clk),
		.we    (lg_we),
		.waddr (lg_waddr),
		.wdata (lg_wdata),
		.re    (lg_re),
		.raddr (lg_raddr),
		.rdata (lg_rd)
	);

	gfla_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_inverse_ram (
		.clk   (clk),
		.we    (iv_we),
		.waddr (iv_waddr),
		.wdata (iv_wdata),
		.re    (iv_re),
		.raddr (look_addr),
		.rdata (iv_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			field_degree_q <= DEGREE_RESET;
			poly_taps_q    <= TAPS_RESET;
			tables_valid_q <= 1'b0;
			issue_q        <= 1'b0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			issue_q <= issue_d;
			v_s1    <= (state_q == ST_INV) && issue_q;
			v_s2    <= v_s1;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_FIELD_DEGREE: begin
						field_degree_q <= cfg_data[DEGREE_W-1:0];
						tables_valid_q <= 1'b0;
					end
					REG_POLY_TAPS: begin
						poly_taps_q    <= cfg_data[TAPS_W-1:0];
						tables_valid_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end else if (set_valid) begin
				tables_valid_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cnt_q  <= cnt_d;
		a_q    <= a_d;
		idx_s1 <= cnt_q;
		idx_s2 <= idx_s1;
		if (in_valid && in_ready) begin
			op_q    <= op_t'(op);
			value_q <= value;
		end
	end

	// result beat, flags first then table reads
	logic               zero_c, oor_c, nb_c, look_c;
	logic [WIDE_W-1:0]  n_wide, pw_wide, lg_wide, iv_wide;

	assign n_wide  = WIDE_W'(n_mask);
	assign pw_wide = WIDE_W'(pw_rd);
	assign lg_wide = WIDE_W'(lg_rd);
	assign iv_wide = WIDE_W'(iv_rd);
	assign look_c  = (op_q == OP_LOOKUP);
	assign zero_c  = look_c && (value_q == '0);
	assign oor_c   = look_c && (WIDE_W'(value_q) > n_wide);
	assign nb_c    = look_c && !tables_valid_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			zero_q    <= zero_c;
			oor_q     <= oor_c;
			nb_q      <= nb_c;
			log_q     <= '0;
			antilog_q <= '0;
			inverse_q <= '0;
			if (look_c && !nb_c && !oor_c) begin
				antilog_q <= VALUE_W'(pw_wide);
				if (!zero_c) begin
					log_q     <= VALUE_W'(lg_wide);
					inverse_q <= VALUE_W'(iv_wide);
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign log_result     = log_q;
	assign antilog_result = antilog_q;
	assign inverse_result = inverse_q;
	assign zero_input     = zero_q;
	assign out_of_range   = oor_q;
	assign not_built      = nb_q;

endmodule

`default_nettype wire

@@ hw/rtl/gfla_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gfla_checker
	import gfla_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [VALUE_W-1:0]     log_result,
	input wire logic [VALUE_W-1:0]     antilog_result,
	input wire logic [VALUE_W-1:0]     inverse_result,
	input wire logic                   zero_input,
	input wire logic                   out_of_range,
	input wire logic                   not_built
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(log_result)
			&& $stable(antilog_result) && $stable(inverse_result))
		else $error("result beat changed under stall");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	a_unbuilt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_built |-> log_result == '0 && antilog_result == '0
			&& inverse_result == '0)
		else $error("table data shown before a build");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> !zero_input && log_result == '0
			&& antilog_result == '0 && inverse_result == '0)
		else $error("out of range lookup shows table data");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_input && !not_built |-> log_result == '0
			&& inverse_result == '0 && antilog_result == VALUE_W'(1))
		else $error("zero input gives wrong results");

endmodule

bind gf2m_log_antilog_table_engine_top gfla_checker u_gfla_checker (.*);

`default_nettype wire

@@ dv/gf2m_log_antilog_table_engine_top_tb.sv @@
`timescale 1ns / 1ps

module gf2m_log_antilog_table_engine_top_tb;
	import gfla_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int N_DIR       = 28;

	typedef struct packed {
		logic [VALUE_W-1:0] lg;
		logic [VALUE_W-1:0] al;
		logic [VALUE_W-1:0] iv;
		logic               zero;
		logic               oor;
		logic               nb;
	} field_answer_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		cfg_reg_t           reg_sel;
		logic [7:0]         cfg_val;
		op_t                op;
		logic [VALUE_W-1:0] val;
		logic               typed;
		field_answer_t      want;
	} plan_row_t;

	localparam field_answer_t NO_ANSWER = '0;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	cfg_reg_t               cfg_index = REG_FIELD_DEGREE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	op_t                    drv_op = OP_LOOKUP;
	logic [VALUE_W-1:0]     drv_value = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [VALUE_W-1:0]     log_result;
	logic [VALUE_W-1:0]     antilog_result;
	logic [VALUE_W-1:0]     inverse_result;
	logic                   zero_input;
	logic                   out_of_range;
	logic                   not_built;

	// own copy of the field tables and registers
	logic [7:0]    pow_tbl [0:255];
	logic [7:0]    log_tbl [0:255];
	logic [7:0]    inv_tbl [0:255];
	bit            tbl_built = 1'b0;
	logic [3:0]    degree_q = DEGREE_RESET;
	logic [7:0]    taps_q = TAPS_RESET;

	field_answer_t answers_due [$];
	int            mismatches = 0;
	int            cycles = 0;
	int            items_sent = 0;
	int            gap_pct = 0;
	int            stall_pct = 0;
	plan_row_t     directed [N_DIR];

	gf2m_log_antilog_table_engine_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (drv_op),
		.value          (drv_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.log_result     (log_result),
		.antilog_result (antilog_result),
		.inverse_result (inverse_result),
		.zero_input     (zero_input),
		.out_of_range   (out_of_range),
		.not_built      (not_built)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned eff_m(logic [3:0] d);
		int unsigned m;
		m = d;
		if (m < MIN_DEGREE) m = MIN_DEGREE;
		if (m > MAX_DEGREE_DEF) m = MAX_DEGREE_DEF;
		return m;
	endfunction

	// galois lfsr walk, then inverse from the log store
	function automatic void build_field();
		int unsigned m, n, top, tp, a, e;
		m = eff_m(degree_q);
		n = (1 << m) - 1;
		top = 1 << (m - 1);
		tp = taps_q & n;
		a = 1;
		for (int unsigned i = 0; i < 256; i++) log_tbl[i] = '0;
		for (int unsigned i = 0; i < n; i++) begin
			pow_tbl[i] = 8'(a);
			log_tbl[a & n] = 8'(i);
			if ((a & top) != 0) a = (((a ^ top) << 1) ^ tp) & n;
			else a = (a << 1) & n;
		end
		pow_tbl[n] = 8'd1;
		log_tbl[0] = 8'd0;
		for (int unsigned i = 0; i <= n; i++) begin
			e = (n - (log_tbl[i] % n)) % n;
			inv_tbl[i] = pow_tbl[e];
		end
		inv_tbl[0] = 8'd0;
		tbl_built = 1'b1;
	endfunction

	function automatic field_answer_t field_answer(op_t o, logic [VALUE_W-1:0] v);
		field_answer_t r;
		int unsigned   n;
		r = '0;
		if (o == OP_BUILD) begin
			build_field();
		end else begin
			n = (1 << eff_m(degree_q)) - 1;
			r.zero = (v == 0);
			r.oor = (v > n);
			r.nb = !tbl_built;
			if (!r.nb && !r.oor) begin
				r.al = pow_tbl[v];
				if (!r.zero) begin
					r.lg = log_tbl[v];
					r.iv = inv_tbl[v];
				end
			end
		end
		return r;
	endfunction

	task automatic send_beat(op_t o, logic [VALUE_W-1:0] v, bit typed, field_answer_t want);
		field_answer_t r;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		drv_op <= o;
		drv_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = field_answer(o, v);
		answers_due.push_back(typed ? want : r);
		items_sent++;
	endtask

	// hold off until every pending result is back and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_FIELD_DEGREE) degree_q = data[3:0];
		else taps_q = data;
		tbl_built = 1'b0;
	endtask

	// new field setting, at times lookups ahead of the build, a build, then mostly in-field lookups
	task automatic run_segment();
		logic [7:0]  deg_b, taps_b, prim;
		int unsigned m, n, cnt;
		if ($urandom_range(0, 9) == 0) deg_b = 8'($urandom_range(0, 255));
		else deg_b = 8'(($urandom_range(0, 15) << 4) | $urandom_range(2, 8));
		m = eff_m(deg_b[3:0]);
		n = (1 << m) - 1;
		case (m)
			5:       prim = 8'h05;
			8:       prim = 8'h1d;
			default: prim = 8'h03;
		endcase
		if ($urandom_range(0, 1) == 0) taps_b = prim | (8'($urandom()) & ~8'(n));
		else taps_b = 8'($urandom());
		settle();
		if ($urandom_range(0, 1) == 0) begin
			write_reg(REG_FIELD_DEGREE, deg_b);
			write_reg(REG_POLY_TAPS, taps_b);
		end else begin
			write_reg(REG_POLY_TAPS, taps_b);
			write_reg(REG_FIELD_DEGREE, deg_b);
		end
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 4))
				send_beat(OP_LOOKUP, 8'($urandom()), 1'b0, NO_ANSWER);
		end
		send_beat(OP_BUILD, 8'($urandom()), 1'b0, NO_ANSWER);
		cnt = $urandom_range(20, 60);
		for (int unsigned k = 0; k < cnt; k++) begin
			if ($urandom_range(0, 39) == 0)
				send_beat(OP_BUILD, 8'($urandom()), 1'b0, NO_ANSWER);
			else if ($urandom_range(0, 99) < 85)
				send_beat(OP_LOOKUP, 8'($urandom_range(0, n)), 1'b0, NO_ANSWER);
			else
				send_beat(OP_LOOKUP, 8'($urandom_range(0, 255)), 1'b0, NO_ANSWER);
		end
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		field_answer_t w;
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				$error("result beat with nothing pending");
				mismatches++;
			end else begin
				w = answers_due.pop_front();
				check_field("log_result", w.lg, log_result);
				check_field("antilog_result", w.al, antilog_result);
				check_field("inverse_result", w.iv, inverse_result);
				check_field("zero_input", 8'(w.zero), 8'(zero_input));
				check_field("out_of_range", 8'(w.oor), 8'(out_of_range));
				check_field("not_built", 8'(w.nb), 8'(not_built));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int phase_start;
		directed = '{
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h00, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1}},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'hff, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1}},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_BUILD,  8'ha5, 1'b1, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h00, 1'b1, '{8'd0, 8'd1, 8'd0, 1'b1, 1'b0, 1'b0}},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h01, 1'b1, '{8'd0, 8'd2, 8'd1, 1'b0, 1'b0, 1'b0}},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h02, 1'b0, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'hff, 1'b0, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h80, 1'b0, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h55, 1'b0, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'haa, 1'b0, NO_ANSWER},
			// smallest field, lookups before its build
			'{ROW_CFG,  REG_FIELD_DEGREE, 8'h02, OP_LOOKUP, 8'h00, 1'b0, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h03, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1}},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h04, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1}},
			// taps above the degree are dropped
			'{ROW_CFG,  REG_POLY_TAPS,    8'hff, OP_LOOKUP, 8'h00, 1'b0, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_BUILD,  8'h5a, 1'b1, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h03, 1'b0, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h04, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0}},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'hff, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0}},
			// degree zero clamps up to two
			'{ROW_CFG,  REG_FIELD_DEGREE, 8'hf0, OP_LOOKUP, 8'h00, 1'b0, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_BUILD,  8'hff, 1'b1, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h02, 1'b0, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h00, 1'b1, '{8'd0, 8'd1, 8'd0, 1'b1, 1'b0, 1'b0}},
			// degree 15 clamps to 8, no taps gives a non-primitive walk
			'{ROW_CFG,  REG_FIELD_DEGREE, 8'h0f, OP_LOOKUP, 8'h00, 1'b0, NO_ANSWER},
			'{ROW_CFG,  REG_POLY_TAPS,    8'h00, OP_LOOKUP, 8'h00, 1'b0, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_BUILD,  8'h00, 1'b1, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h80, 1'b0, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'h03, 1'b0, NO_ANSWER},
			'{ROW_ITEM, REG_FIELD_DEGREE, 8'h00, OP_LOOKUP, 8'hff, 1'b0, NO_ANSWER}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 8;
		stall_pct = 66;
		for (int r = 0; r < N_DIR; r++) begin
			if (directed[r].kind == ROW_CFG) begin
				settle();
				write_reg(directed[r].reg_sel, directed[r].cfg_val);
			end else begin
				send_beat(directed[r].op, directed[r].val, directed[r].typed, directed[r].want);
			end
		end

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					gap_pct = 8;
					stall_pct = 66;
				end
				1: begin
					gap_pct = 66;
					stall_pct = 8;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < 342) run_segment();
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
